[design/assert_macros.svh]
// Assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset
`define LCGRR_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define LCGRR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/lcgrr_pkg.sv]
// Package: types, constants and command/status structs of the ranged LCG block
package lcgrr_pkg;

  localparam int WORD_W  = 32;
  localparam int STATE_W = 64;
  localparam int MULT_SHIFT = 30;
  localparam int CFG_IDX_W = 1;

  localparam logic [STATE_W-1:0] LCG_INC = 64'd1234567891;

  localparam logic OP_RAW    = 1'b0;
  localparam logic OP_RANGED = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SEED_UPPER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_LOWER = 1'b1;

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic signed [WORD_W-1:0] limit_t;
  typedef logic [STATE_W-1:0]       lcg_state_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  typedef struct packed {
    logic load_in;
    logic draw;
    logic mul;
    logic check;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic err;
    logic fit;
  } status_t;

endpackage

[design/lcgrr_in_if.sv]
// Request channel: opcode and signed limits
interface lcgrr_in_if;
  import lcgrr_pkg::*;
  logic   valid;
  logic   ready;
  logic   opcode;
  limit_t lo_bound;
  limit_t hi_bound;

  modport source (output valid, opcode, lo_bound, hi_bound, input ready);
  modport sink (input valid, opcode, lo_bound, hi_bound, output ready);
endinterface

[design/lcgrr_out_if.sv]
// Result channel: value and range error flag
interface lcgrr_out_if;
  import lcgrr_pkg::*;
  logic  valid;
  logic  ready;
  word_t value;
  logic  bad_range;

  modport source (output valid, value, bad_range, input ready);
  modport sink (input valid, value, bad_range, output ready);
endinterface

[design/lcgrr_ctrl.sv]
// Controller: sequences load, draw, scale multiply, check and result hand-off
module lcgrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lcgrr_pkg::status_t status,
  output lcgrr_pkg::cmd_t    cmd
);
  import lcgrr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DRAW = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DRAW;
        end
      end
      S_DRAW: begin
        if (status.op == OP_RANGED && status.err) begin
          state_nxt = S_DONE;
        end else begin
          cmd.draw  = 1'b1;
          state_nxt = (status.op == OP_RAW) ? S_DONE : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.check = 1'b1;
        state_nxt = status.fit ? S_DONE : S_DRAW;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/lcgrr_dpath.sv]
// Datapath: seed registers, generator state, scaling multiply and result register
module lcgrr_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  lcgrr_pkg::cfg_idx_t cfg_index,
  input  lcgrr_pkg::word_t    cfg_wdata,
  input  logic                in_opcode,
  input  lcgrr_pkg::limit_t   in_lo_bound,
  input  lcgrr_pkg::limit_t   in_hi_bound,
  input  lcgrr_pkg::cmd_t     cmd,
  output lcgrr_pkg::status_t  status,
  output lcgrr_pkg::word_t    out_value,
  output logic                out_bad_range
);
  import lcgrr_pkg::*;

  word_t      seed_upper_r, seed_upper_nxt;
  word_t      seed_lower_r, seed_lower_nxt;
  lcg_state_t gen_r, gen_nxt, gen_step;
  logic       op_r, err_r;
  word_t      lo_r, span_r, draw_r, t_r, value_r;
  logic       bad_range_r;
  lcg_state_t prod_r;
  lcg_state_t scaled;
  word_t      t_cand;

  // state * (2^30 + 1) + inc, mod 2^64
  assign gen_step = gen_r + (gen_r << MULT_SHIFT) + LCG_INC;

  // draw * (span + 2) = draw * span + 2 * draw
  assign scaled = prod_r + {{(STATE_W-WORD_W-1){1'b0}}, draw_r, 1'b0};
  assign t_cand = scaled[STATE_W-1:WORD_W];

  assign status.op  = op_r;
  assign status.err = err_r;
  assign status.fit = (t_cand <= span_r);

  always_comb begin
    seed_upper_nxt = seed_upper_r;
    seed_lower_nxt = seed_lower_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED_UPPER: seed_upper_nxt = cfg_wdata;
        REG_SEED_LOWER: seed_lower_nxt = cfg_wdata;
        default: ;
      endcase
    end
    if (cfg_we) begin
      gen_nxt = {seed_upper_nxt, seed_lower_nxt};
    end else if (cmd.draw) begin
      gen_nxt = gen_step;
    end else begin
      gen_nxt = gen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_upper_r <= '0;
      seed_lower_r <= '0;
      gen_r        <= '0;
    end else begin
      seed_upper_r <= seed_upper_nxt;
      seed_lower_r <= seed_lower_nxt;
      gen_r        <= gen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_opcode;
      err_r  <= (in_lo_bound > in_hi_bound);
      lo_r   <= word_t'(in_lo_bound);
      span_r <= word_t'(in_hi_bound) - word_t'(in_lo_bound);
    end
    if (cmd.draw) begin
      draw_r <= gen_step[STATE_W-1:WORD_W];
    end
    if (cmd.mul) begin
      prod_r <= {{(STATE_W-WORD_W){1'b0}}, draw_r} * {{(STATE_W-WORD_W){1'b0}}, span_r};
    end
    if (cmd.check) begin
      t_r <= t_cand;
    end
    if (cmd.load_out) begin
      if (op_r == OP_RAW) begin
        value_r     <= draw_r;
        bad_range_r <= 1'b0;
      end else if (err_r) begin
        value_r     <= '0;
        bad_range_r <= 1'b1;
      end else begin
        value_r     <= lo_r + t_r;
        bad_range_r <= 1'b0;
      end
    end
  end

  assign out_value     = value_r;
  assign out_bad_range = bad_range_r;

endmodule

[design/lcg_ranged_random.sv]
// Ranged LCG random block: 64-bit linear congruential generator with raw and
// bounded draws. A raw draw, or a request whose lower limit exceeds its upper
// limit, passes through the draw and done states before its result is loaded
// into the output register; a ranged draw repeats draw, multiply and check
// until the rejection test accepts. Each ranged draw costs one state update (a
// shift and add), one 32x32 scaling multiply and one threshold check in
// sequence. One request is in flight at a time; the next request is taken as
// soon as the previous result sits in the output register. A result waits in
// the output register while the receiver stalls and holds off the next one.
// Seed writes reload the state.
`include "assert_macros.svh"

module lcg_ranged_random (
  input  logic                clk,
  input  logic                rst_n,
  lcgrr_in_if.sink            in_if,
  lcgrr_out_if.source         out_if,
  input  logic                cfg_we,
  input  lcgrr_pkg::cfg_idx_t cfg_index,
  input  lcgrr_pkg::word_t    cfg_wdata
);
  import lcgrr_pkg::*;

  cmd_t    cmd;
  status_t status;

  lcgrr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lcgrr_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_opcode     (in_if.opcode),
    .in_lo_bound   (in_if.lo_bound),
    .in_hi_bound   (in_if.hi_bound),
    .cmd           (cmd),
    .status        (status),
    .out_value     (out_if.value),
    .out_bad_range (out_if.bad_range)
  );

  `LCGRR_ASSERT_ALWAYS(a_err_value_zero,
    !(out_if.valid && out_if.bad_range) || (out_if.value == '0),
    "range error with nonzero value")
  `LCGRR_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command")
  `LCGRR_ASSERT_NEXT(a_busy_after_load, cmd.load_in, !in_if.ready, "request taken while busy")
  `LCGRR_ASSERT_NEXT(a_mul_then_check, cmd.mul, cmd.check, "multiply not followed by check")
  `LCGRR_ASSERT_NEXT(a_load_shows_result, cmd.load_out, out_if.valid, "result not presented")

endmodule
